>>> rtl/b2g_pkg.sv
`default_nettype none

package b2g_pkg;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] TRAIL_LOW  = 8'h40;
    localparam logic [7:0] TRAIL_HIGH = 8'hFE;
    localparam logic [7:0] MISS_BYTE  = 8'h5F;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ILLEGAL    = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_EMIT,
        OP_LOOKUP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [13:0] index;
        logic [15:0] data;
        logic [15:0] value;
        logic        has_byte;
        status_t     status;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PROBE,
        B_CMP,
        B_EMIT_HI,
        B_EMIT_LO
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/b2g_front.sv
`default_nettype none

module b2g_front
    import b2g_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  in_byte,
    input  wire logic [13:0] entry_index,
    input  wire logic [15:0] entry_key,
    input  wire logic [15:0] entry_value,
    output logic             push,
    output cmd_t             push_cmd
);

    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] lead_byte_reg;
    logic [7:0] lead_byte_next;
    logic       slot_ok;
    logic       trail_ok;

    assign slot_ok  = 17'(entry_index) < 17'(TABLE_DEPTH);
    assign trail_ok = (in_byte >= TRAIL_LOW) && (in_byte <= TRAIL_HIGH);

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        push              = 1'b0;
        push_cmd.op       = OP_EMIT;
        push_cmd.index    = entry_index;
        push_cmd.data     = entry_key;
        push_cmd.value    = entry_value;
        push_cmd.has_byte = 1'b0;
        push_cmd.status   = ST_OK;
        if (accept)
        begin
            priority if (kind == KIND_LOAD)
            begin
                push        = slot_ok;
                push_cmd.op = OP_LOAD;
            end
            else if (kind == KIND_DATA)
            begin
                priority if (!lead_pending_reg && in_byte[7])
                begin
                    lead_byte_next    = in_byte;
                    lead_pending_next = 1'b1;
                end
                else if (!lead_pending_reg)
                begin
                    push              = 1'b1;
                    push_cmd.data     = {8'h00, in_byte};
                    push_cmd.has_byte = 1'b1;
                end
                else if (trail_ok)
                begin
                    push              = 1'b1;
                    push_cmd.op       = OP_LOOKUP;
                    push_cmd.data     = {lead_byte_reg, in_byte};
                    lead_pending_next = 1'b0;
                end
                else
                begin
                    push            = 1'b1;
                    push_cmd.data   = 16'h0000;
                    push_cmd.status = ST_ILLEGAL;
                end
            end
            else if (kind == KIND_END)
            begin
                push              = lead_pending_reg;
                push_cmd.data     = 16'h0000;
                push_cmd.status   = ST_INCOMPLETE;
                lead_pending_next = 1'b0;
            end
            else
            begin
                push = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b2g_cmd_fifo.sv
`default_nettype none

module b2g_cmd_fifo
    import b2g_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = count_reg == 2'd2;
    assign valid   = count_reg != 2'd0;
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b2g_back.sv
`default_nettype none

module b2g_back
    import b2g_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [14:0] entry_count,
    input  wire logic        cmd_valid,
    input  wire cmd_t        cmd,
    output logic             cmd_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_has_byte,
    output status_t          out_status,
    output logic             out_last
);

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW     = (CNT_W > 15) ? CNT_W : 15;

    logic [15:0] key_mem [TABLE_DEPTH];
    logic [15:0] val_mem [TABLE_DEPTH];

    back_state_t state_reg;
    back_state_t state_next;

    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] lo_next;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] hi_next;
    logic [CNT_W-1:0] mid_reg;
    logic [CNT_W-1:0] mid_next;
    logic [15:0]      code_reg;
    logic [15:0]      code_next;
    logic [7:0]       res_hi_reg;
    logic [7:0]       res_hi_next;
    logic [7:0]       res_lo_reg;
    logic [7:0]       res_lo_next;
    logic             res_has_reg;
    logic             res_has_next;
    status_t          res_status_reg;
    status_t          res_status_next;
    logic [15:0]      key_rd_reg;
    logic [15:0]      val_rd_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_has_reg;
    status_t          out_status_reg;
    logic             out_last_reg;

    logic [CW-1:0]    count_ext;
    logic [CW-1:0]    count_sat;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] mid_inc;
    logic [15:0]      wr_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic             out_load;
    logic             mem_we;
    logic             emit_hi;
    logic             emit_lo;

    assign count_ext = CW'(entry_count);
    assign count_sat = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;
    assign n_cnt     = count_sat[CNT_W-1:0];
    assign mid_sum   = (CNT_W + 1)'(lo_reg) + (CNT_W + 1)'(hi_reg) - (CNT_W + 1)'(1);
    assign mid_calc  = mid_sum[CNT_W:1];
    assign mid_inc   = mid_reg + CNT_W'(1);
    assign wr_idx    = 16'(cmd.index);
    assign wr_addr   = wr_idx[ADDR_W-1:0];
    assign rd_addr   = mid_calc[ADDR_W-1:0];
    assign out_load  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_LOAD:   state_next = B_IDLE;
                        OP_EMIT:   state_next = B_EMIT_LO;
                        OP_LOOKUP: state_next = (n_cnt == '0) ? B_EMIT_HI : B_PROBE;
                        default:   state_next = B_IDLE;
                    endcase
                end
            end
            B_PROBE:
            begin
                state_next = B_CMP;
            end
            B_CMP:
            begin
                priority if (code_reg == key_rd_reg)
                begin
                    state_next = B_EMIT_HI;
                end
                else if (code_reg < key_rd_reg)
                begin
                    state_next = (lo_reg < mid_reg) ? B_PROBE : B_EMIT_HI;
                end
                else
                begin
                    state_next = (mid_inc < hi_reg) ? B_PROBE : B_EMIT_HI;
                end
            end
            B_EMIT_HI:
            begin
                if (out_load)
                begin
                    state_next = B_EMIT_LO;
                end
            end
            B_EMIT_LO:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop = (state_reg == B_IDLE) && cmd_valid;
        mem_we  = cmd_pop && (cmd.op == OP_LOAD);
        emit_hi = (state_reg == B_EMIT_HI) && out_load;
        emit_lo = (state_reg == B_EMIT_LO) && out_load;
    end

    always_comb
    begin
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        code_next       = code_reg;
        res_hi_next     = res_hi_reg;
        res_lo_next     = res_lo_reg;
        res_has_next    = res_has_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                lo_next         = '0;
                hi_next         = n_cnt;
                code_next       = cmd.data;
                res_hi_next     = MISS_BYTE;
                res_lo_next     = (cmd.op == OP_EMIT) ? cmd.data[7:0] : MISS_BYTE;
                res_has_next    = (cmd.op == OP_EMIT) ? cmd.has_byte : 1'b1;
                res_status_next = (cmd.op == OP_EMIT) ? cmd.status : ST_OK;
            end
            B_PROBE:
            begin
                mid_next = mid_calc;
            end
            B_CMP:
            begin
                priority if (code_reg == key_rd_reg)
                begin
                    res_hi_next = val_rd_reg[15:8];
                    res_lo_next = val_rd_reg[7:0];
                end
                else if (code_reg < key_rd_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_inc;
                end
            end
            B_EMIT_HI, B_EMIT_LO:
            begin
                lo_next = lo_reg;
            end
            default:
            begin
                lo_next = lo_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (emit_hi || emit_lo)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_addr] <= cmd.data;
            val_mem[wr_addr] <= cmd.value;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        code_reg       <= code_next;
        res_hi_reg     <= res_hi_next;
        res_lo_reg     <= res_lo_next;
        res_has_reg    <= res_has_next;
        res_status_reg <= res_status_next;
        if (emit_hi)
        begin
            out_byte_reg   <= res_hi_reg;
            out_has_reg    <= 1'b1;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
        end
        else if (emit_lo)
        begin
            out_byte_reg   <= res_lo_reg;
            out_has_reg    <= res_has_reg;
            out_status_reg <= res_status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_has_byte = out_has_reg;
    assign out_status   = out_status_reg;
    assign out_last     = out_last_reg;

`ifndef NO_ASSERTIONS
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PROBE) |-> (lo_reg < hi_reg))
        else $error("probe issued on empty search range");

    a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CMP) |-> ($past(state_reg) == B_PROBE))
        else $error("compare without a preceding probe");

    a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
        emit_hi |=> (state_reg == B_EMIT_LO) && out_valid_reg && !out_last_reg)
        else $error("high byte not followed by low byte");

    a_write_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == B_IDLE) && cmd_valid)
        else $error("table write outside a command pop");
`endif

endmodule

`default_nettype wire

>>> rtl/big5_to_gbk_stream_converter_unit.sv
// A pass-through or error byte goes through the command FIFO and the back-end state machine
// to the registered output. A two-byte code is looked up with P probes of the key memory,
// P at most ceil(log2(entry_count + 1)), 15 for 16384 entries; its second byte follows.
// The back end works on one command at a time; the two-entry FIFO takes input while it has room.
// Reset: asynchronous, active low; clears the pending lead, entry_count and all control.
// Table memory is not cleared; load every slot below entry_count before use.
`default_nettype none

module big5_to_gbk_stream_converter_unit
    import b2g_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        entry_count_wr_en,
    input  wire logic [14:0] entry_count_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // in_byte[7:0], entry_index[21:8], entry_key[37:22], entry_value[53:38], zero[55:54]
    input  wire logic [55:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]       m_axis_tdata,
    // has_byte[0], status[2:1]
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    logic [14:0] entry_count_reg;
    logic        accept;
    logic        push;
    cmd_t        push_cmd;
    logic        fifo_full;
    logic        fifo_valid;
    logic        fifo_pop;
    cmd_t        fifo_cmd;
    logic        out_has_byte;
    status_t     out_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 15'd0;
        end
        else if (entry_count_wr_en)
        begin
            entry_count_reg <= entry_count_wr_data;
        end
    end

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    b2g_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (s_axis_tuser),
        .in_byte     (s_axis_tdata[7:0]),
        .entry_index (s_axis_tdata[21:8]),
        .entry_key   (s_axis_tdata[37:22]),
        .entry_value (s_axis_tdata[53:38]),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    b2g_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .valid    (fifo_valid),
        .pop_cmd  (fifo_cmd)
    );

    b2g_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_count  (entry_count_reg),
        .cmd_valid    (fifo_valid),
        .cmd          (fifo_cmd),
        .cmd_pop      (fifo_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .out_has_byte (out_has_byte),
        .out_status   (out_status),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tuser = {out_status, out_has_byte};

endmodule

`default_nettype wire
